// ===== sv/bleadv_pkg.sv =====
// Shared types and constants for the LE advertising report event parser.
// No dependencies; used by bleadv_parser and ble_adv_report_event_parser.
package bleadv_pkg;

    // H4 / HCI codes checked in the packet header
    localparam logic [7:0] H4_EVENT_TYPE   = 8'h04;
    localparam logic [7:0] LE_META_EVENT   = 8'h3E;
    localparam logic [7:0] ADV_REPORT_SUB  = 8'h02;

    localparam int unsigned ADDR_BYTES     = 6;

    // Result status codes
    localparam logic [1:0] STATUS_REPORT    = 2'd0;
    localparam logic [1:0] STATUS_DATA      = 2'd1;
    localparam logic [1:0] STATUS_NOT_ADV   = 2'd2;
    localparam logic [1:0] STATUS_BAD_COUNT = 2'd3;

    typedef struct packed {
        logic [7:0]  packet_byte;
        logic        packet_start;
        logic [62:0] arrival_time;
    } pkt_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [4:0]        report_number;
        logic [7:0]        event_kind;
        logic [7:0]        address_kind;
        logic [47:0]       device_address;
        logic [4:0]        data_length;
        logic signed [7:0] signal_strength;
        logic [7:0]        data_value;
        logic [4:0]        data_offset;
        logic [62:0]       report_time;
        logic              final_result;
    } rpt_word_t;

endpackage

// ===== sv/bleadv_parser.sv =====
// Byte-level state machine of the advertising report parser.
// Holds the parse state; gives at most one result per consumed byte.
// Depends on bleadv_pkg.
module bleadv_parser #(
    parameter int unsigned MAX_REPORTS   = 25,
    parameter int unsigned DATA_CAPACITY = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  bleadv_pkg::pkt_word_t word,
    output bleadv_pkg::rpt_word_t res,
    output logic                  res_valid
);

    localparam int unsigned RW = $clog2(MAX_REPORTS + 1);
    localparam int unsigned KW = $clog2(DATA_CAPACITY + 1);

    typedef enum logic [3:0] {
        PH_IDLE, PH_EVCODE, PH_PLEN, PH_SUBEV, PH_COUNT, PH_EVTYPE,
        PH_ADDRTYPE, PH_ADDR, PH_DLEN, PH_DATA, PH_RSSI
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [RW-1:0] expected_reg, expected_next;
    logic [RW-1:0] done_reg, done_next;
    logic [RW-1:0] done_inc;
    logic [2:0]    addr_cnt_reg, addr_cnt_next;
    logic [47:0]   addr_reg, addr_next;
    logic [7:0]    evkind_reg, evkind_next;
    logic [7:0]    adkind_reg, adkind_next;
    logic [7:0]    left_reg, left_next;
    logic [7:0]    left_dec;
    logic [KW-1:0] kept_reg, kept_next;
    logic [62:0]   time_reg, time_next;
    logic [7:0]    b;

    assign b        = word.packet_byte;
    assign done_inc = done_reg + RW'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        expected_next = expected_reg;
        done_next     = done_reg;
        addr_cnt_next = addr_cnt_reg;
        addr_next     = addr_reg;
        evkind_next   = evkind_reg;
        adkind_next   = adkind_reg;
        left_next     = left_reg;
        kept_next     = kept_reg;
        time_next     = time_reg;
        left_dec      = left_reg;
        res           = '0;
        res_valid     = 1'b0;

        if (fire)
        begin
            if (word.packet_start)
            begin
                time_next     = word.arrival_time;
                expected_next = '0;
                done_next     = '0;
                if (b != bleadv_pkg::H4_EVENT_TYPE)
                begin
                    res_valid        = 1'b1;
                    res.status       = bleadv_pkg::STATUS_NOT_ADV;
                    res.report_time  = word.arrival_time;
                    res.final_result = 1'b1;
                    phase_next       = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_EVCODE;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_EVCODE, PH_SUBEV:
                    begin
                        if ((phase_reg == PH_EVCODE && b != bleadv_pkg::LE_META_EVENT) ||
                            (phase_reg == PH_SUBEV && b != bleadv_pkg::ADV_REPORT_SUB))
                        begin
                            res_valid        = 1'b1;
                            res.status       = bleadv_pkg::STATUS_NOT_ADV;
                            res.report_time  = time_reg;
                            res.final_result = 1'b1;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = (phase_reg == PH_EVCODE) ? PH_PLEN : PH_COUNT;
                        end
                    end
                    PH_PLEN:
                    begin
                        phase_next = PH_SUBEV;
                    end
                    PH_COUNT:
                    begin
                        if (b == 8'd0 || {1'b0, b} > 9'(MAX_REPORTS))
                        begin
                            res_valid        = 1'b1;
                            res.status       = bleadv_pkg::STATUS_BAD_COUNT;
                            res.report_time  = time_reg;
                            res.final_result = 1'b1;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            expected_next = RW'(b);
                            done_next     = '0;
                            phase_next    = PH_EVTYPE;
                        end
                    end
                    PH_EVTYPE:
                    begin
                        evkind_next = b;
                        phase_next  = PH_ADDRTYPE;
                    end
                    PH_ADDRTYPE:
                    begin
                        adkind_next   = b;
                        addr_next     = '0;
                        addr_cnt_next = '0;
                        phase_next    = PH_ADDR;
                    end
                    PH_ADDR:
                    begin
                        addr_next[{addr_cnt_reg, 3'b000} +: 8] = b;
                        if (addr_cnt_reg == 3'(bleadv_pkg::ADDR_BYTES - 1))
                        begin
                            addr_cnt_next = '0;
                            phase_next    = PH_DLEN;
                        end
                        else
                        begin
                            addr_cnt_next = addr_cnt_reg + 3'd1;
                        end
                    end
                    PH_DLEN:
                    begin
                        left_next  = b;
                        kept_next  = '0;
                        phase_next = (b == 8'd0) ? PH_RSSI : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        if (kept_reg < KW'(DATA_CAPACITY))
                        begin
                            res_valid          = 1'b1;
                            res.status         = bleadv_pkg::STATUS_DATA;
                            res.report_number  = 5'(done_reg);
                            res.event_kind     = evkind_reg;
                            res.address_kind   = adkind_reg;
                            res.device_address = addr_reg;
                            res.report_time    = time_reg;
                            res.data_value     = b;
                            res.data_offset    = 5'(kept_reg);
                            kept_next          = kept_reg + KW'(1);
                        end
                        // every raw byte is consumed, kept or not
                        if (left_reg != 8'd0)
                        begin
                            left_dec = left_reg - 8'd1;
                        end
                        left_next = left_dec;
                        if (left_dec == 8'd0)
                        begin
                            phase_next = PH_RSSI;
                        end
                    end
                    PH_RSSI:
                    begin
                        res_valid           = 1'b1;
                        res.status          = bleadv_pkg::STATUS_REPORT;
                        res.report_number   = 5'(done_reg);
                        res.event_kind      = evkind_reg;
                        res.address_kind    = adkind_reg;
                        res.device_address  = addr_reg;
                        res.report_time     = time_reg;
                        res.data_length     = 5'(kept_reg);
                        res.signal_strength = $signed(b);
                        done_next           = done_inc;
                        if (done_inc >= expected_reg)
                        begin
                            res.final_result = 1'b1;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_EVTYPE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            expected_reg <= '0;
            done_reg     <= '0;
            addr_cnt_reg <= '0;
            left_reg     <= '0;
            kept_reg     <= '0;
            addr_reg     <= '0;
            evkind_reg   <= '0;
            adkind_reg   <= '0;
            time_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            done_reg     <= done_next;
            addr_cnt_reg <= addr_cnt_next;
            left_reg     <= left_next;
            kept_reg     <= kept_next;
            addr_reg     <= addr_next;
            evkind_reg   <= evkind_next;
            adkind_reg   <= adkind_next;
            time_reg     <= time_next;
        end
    end

endmodule

// ===== sv/ble_adv_report_event_parser.sv =====
// Top level of the LE advertising report event parser.
// Input word register, bleadv_parser state machine, result word register.
// Depends on bleadv_pkg and bleadv_parser.
//
// Usage:
//   pkt channel: one H4 HCI packet byte per word, with packet_start on the
//   first byte of a packet and arrival_time sampled on that byte.
//   rpt channel: data byte words (status 1), report words (status 0) on the
//   RSSI byte, and error words (status 2 or 3) that end the packet.
//   A word is taken at a rising edge with valid high and stall low.
// Timing:
//   One byte per cycle sustained while rpt_stall holds no waiting result. A taken
//   byte is first held in the input register, then parser logic loads its result
//   into the result register, which drives rpt. Bytes with no result advance the state.
// Stall:
//   When rpt_stall holds a waiting result, the registered byte is held and
//   pkt_stall rises; one byte stays buffered in the input register.
// Reset:
//   rst_n low clears both valid flags and returns the parser to idle; bytes
//   are then ignored until the next packet_start.
module ble_adv_report_event_parser #(
    parameter int unsigned MAX_REPORTS   = 25,
    parameter int unsigned DATA_CAPACITY = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pkt_valid,
    output logic                  pkt_stall,
    input  bleadv_pkg::pkt_word_t pkt,
    output logic                  rpt_valid,
    input  logic                  rpt_stall,
    output bleadv_pkg::rpt_word_t rpt
);

    logic                  in_vld_reg;
    bleadv_pkg::pkt_word_t in_reg;
    logic                  out_vld_reg, out_vld_next;
    bleadv_pkg::rpt_word_t out_reg;
    logic                  advance;
    logic                  fire;
    bleadv_pkg::rpt_word_t res;
    logic                  res_valid;

    // result register free or being emptied this cycle
    assign advance      = !out_vld_reg || !rpt_stall;
    assign fire         = in_vld_reg && advance;
    assign pkt_stall    = in_vld_reg && !advance;
    assign out_vld_next = advance ? (fire && res_valid) : out_vld_reg;

    bleadv_parser #(
        .MAX_REPORTS   (MAX_REPORTS),
        .DATA_CAPACITY (DATA_CAPACITY)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .word      (in_reg),
        .res       (res),
        .res_valid (res_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!pkt_stall)
            begin
                in_vld_reg <= pkt_valid;
            end
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_valid && !pkt_stall)
        begin
            in_reg <= pkt;
        end
        if (fire && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rpt_valid = out_vld_reg;
    assign rpt       = out_reg;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for ble_adv_report_event_parser: directed and random H4 byte streams.
// Holds a cycle-free parse model and an in-order scoreboard of report words.
// Depends on bleadv_pkg and the parser RTL.
module tb;

    localparam int MAX_REPORTS     = 25;
    localparam int DATA_CAPACITY   = 31;
    localparam int ITEM_TARGET     = 1850;
    localparam int TAIL_WORDS      = 150;   // no idling on either side for the last words
    localparam int PRESSURE_AFTER  = 300;   // results seen before the long receiver hold
    localparam int PRESSURE_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no word taken on either channel
    localparam int DRAIN_CYCLES    = 8;

    // Parse position inside an H4 LE advertising report event
    typedef enum logic [3:0] {
        P_IDLE,
        P_EVENT_CODE,
        P_PARAM_LEN,
        P_SUBEVENT,
        P_COUNT,
        P_EVENT_KIND,
        P_ADDR_KIND,
        P_ADDRESS,
        P_DATA_LEN,
        P_DATA,
        P_RSSI
    } parse_phase_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  pkt_valid = 1'b0;
    logic                  pkt_stall;
    bleadv_pkg::pkt_word_t pkt       = '0;
    logic                  rpt_valid;
    logic                  rpt_stall = 1'b0;
    bleadv_pkg::rpt_word_t rpt;

    ble_adv_report_event_parser #(
        .MAX_REPORTS   (MAX_REPORTS),
        .DATA_CAPACITY (DATA_CAPACITY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt),
        .rpt_valid (rpt_valid),
        .rpt_stall (rpt_stall),
        .rpt       (rpt)
    );

    // Byte words waiting to be offered, and report words the parser owes us
    bleadv_pkg::pkt_word_t pending_words[$];
    bleadv_pkg::rpt_word_t expected_reports[$];
    logic [7:0]            event_bytes[$];

    // Parse model state
    parse_phase_t parse_state   = P_IDLE;
    int           reports_wanted = 0;
    int           reports_seen   = 0;
    int           addr_bytes_in  = 0;
    logic [47:0]  addr_gather    = '0;
    logic [7:0]   kind_event     = '0;
    logic [7:0]   kind_address   = '0;
    int           data_left      = 0;
    int           data_kept      = 0;
    logic [62:0]  stamp_held     = '0;

    // Handshake bookkeeping
    int                    words_taken    = 0;
    int                    total_words    = 0;
    int                    send_gap       = 0;
    int                    stall_left     = 0;
    int                    results_seen   = 0;
    int                    mismatch_count = 0;
    bit                    pressure_done  = 1'b0;
    logic                  quiet_tail     = 1'b0;
    bleadv_pkg::rpt_word_t want;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function logic [62:0] rand_stamp();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    function void push_word(input logic [7:0] b, input logic s, input logic [62:0] t);
        bleadv_pkg::pkt_word_t w;
        w.packet_byte  = b;
        w.packet_start = s;
        w.arrival_time = t;
        pending_words.push_back(w);
    endfunction

    task flag_mismatch(input string what, input logic [63:0] got, input logic [63:0] exp_val);
        mismatch_count++;
        $display("%0t rpt word %0d: %s got %h want %h", $realtime, results_seen, what,
                 got, exp_val);
    endtask

    // Error word: only status, time and the final flag; the rest of the packet is dropped
    task raise_error(input logic [1:0] code);
        bleadv_pkg::rpt_word_t r;
        r              = '0;
        r.status       = code;
        r.report_time  = stamp_held;
        r.final_result = 1'b1;
        expected_reports.push_back(r);
        parse_state = P_IDLE;
    endtask

    // Fields shared by data words and report words
    function bleadv_pkg::rpt_word_t report_head();
        bleadv_pkg::rpt_word_t r;
        r                = '0;
        r.report_number  = reports_seen[4:0];
        r.event_kind     = kind_event;
        r.address_kind   = kind_address;
        r.device_address = addr_gather;
        r.report_time    = stamp_held;
        return r;
    endfunction

    // Advance the parse model by one accepted byte; queue the word it owes, if any
    task parse_byte(input bleadv_pkg::pkt_word_t w);
        bleadv_pkg::rpt_word_t r;
        logic [7:0]            b;
        b = w.packet_byte;
        if (w.packet_start)
        begin
            // a start mark always restarts, even in the middle of a packet
            stamp_held     = w.arrival_time;
            reports_wanted = 0;
            reports_seen   = 0;
            if (b != bleadv_pkg::H4_EVENT_TYPE)
                raise_error(bleadv_pkg::STATUS_NOT_ADV);
            else
                parse_state = P_EVENT_CODE;
        end
        else
        begin
            case (parse_state)
                P_EVENT_CODE:
                    if (b != bleadv_pkg::LE_META_EVENT)
                        raise_error(bleadv_pkg::STATUS_NOT_ADV);
                    else
                        parse_state = P_PARAM_LEN;
                P_PARAM_LEN:
                    parse_state = P_SUBEVENT;
                P_SUBEVENT:
                    if (b != bleadv_pkg::ADV_REPORT_SUB)
                        raise_error(bleadv_pkg::STATUS_NOT_ADV);
                    else
                        parse_state = P_COUNT;
                P_COUNT:
                    if (b < 1 || b > MAX_REPORTS)
                        raise_error(bleadv_pkg::STATUS_BAD_COUNT);
                    else
                    begin
                        reports_wanted = b;
                        reports_seen   = 0;
                        parse_state    = P_EVENT_KIND;
                    end
                P_EVENT_KIND:
                begin
                    kind_event  = b;
                    parse_state = P_ADDR_KIND;
                end
                P_ADDR_KIND:
                begin
                    kind_address  = b;
                    addr_gather   = '0;
                    addr_bytes_in = 0;
                    parse_state   = P_ADDRESS;
                end
                P_ADDRESS:
                begin
                    // first address byte lands in the low byte
                    addr_gather[8*addr_bytes_in +: 8] = b;
                    addr_bytes_in++;
                    if (addr_bytes_in >= bleadv_pkg::ADDR_BYTES)
                    begin
                        addr_bytes_in = 0;
                        parse_state   = P_DATA_LEN;
                    end
                end
                P_DATA_LEN:
                begin
                    data_left   = b;
                    data_kept   = 0;
                    parse_state = (b == 8'd0) ? P_RSSI : P_DATA;
                end
                P_DATA:
                begin
                    // bytes past capacity are eaten without a word
                    if (data_kept < DATA_CAPACITY)
                    begin
                        r             = report_head();
                        r.status      = bleadv_pkg::STATUS_DATA;
                        r.data_value  = b;
                        r.data_offset = data_kept[4:0];
                        data_kept++;
                        expected_reports.push_back(r);
                    end
                    if (data_left > 0)
                        data_left--;
                    if (data_left == 0)
                        parse_state = P_RSSI;
                end
                P_RSSI:
                begin
                    r                 = report_head();
                    r.status          = bleadv_pkg::STATUS_REPORT;
                    r.data_length     = data_kept[4:0];
                    r.signal_strength = b;
                    reports_seen++;
                    if (reports_seen >= reports_wanted)
                    begin
                        r.final_result = 1'b1;
                        parse_state    = P_IDLE;
                    end
                    else
                        parse_state = P_EVENT_KIND;
                    expected_reports.push_back(r);
                end
                default:
                    parse_state = P_IDLE;   // idle or done: byte is ignored
            endcase
        end
    endtask

    // Sender: predicts on every taken word, then offers the next one or idles a burst.
    // A stalled word is held untouched.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_valid <= 1'b0;
            pkt       <= '0;
            send_gap   = 0;
        end
        else
        begin
            if (pkt_valid && !pkt_stall)
            begin
                parse_byte(pkt);
                words_taken++;
            end
            if (!quiet_tail && pending_words.size() < TAIL_WORDS)
                quiet_tail <= 1'b1;
            if (!(pkt_valid && pkt_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    pkt_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    pkt       <= pending_words.pop_front();
                    pkt_valid <= 1'b1;
                    if (!quiet_tail && $urandom_range(0, 11) == 0)
                        send_gap = $urandom_range(1, 16);
                end
                else
                    pkt_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each taken word against the oldest expectation, then picks
    // its stall for the next cycle. One long hold lets the parser back up into pkt_stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpt_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rpt_valid && !rpt_stall)
            begin
                results_seen++;
                if (expected_reports.size() == 0)
                    flag_mismatch("word with none expected, status", rpt.status, '0);
                else
                begin
                    want = expected_reports.pop_front();
                    if (rpt.status !== want.status)
                        flag_mismatch("status", rpt.status, want.status);
                    if (rpt.report_number !== want.report_number)
                        flag_mismatch("report_number", rpt.report_number, want.report_number);
                    if (rpt.event_kind !== want.event_kind)
                        flag_mismatch("event_kind", rpt.event_kind, want.event_kind);
                    if (rpt.address_kind !== want.address_kind)
                        flag_mismatch("address_kind", rpt.address_kind, want.address_kind);
                    if (rpt.device_address !== want.device_address)
                        flag_mismatch("device_address", rpt.device_address,
                                      want.device_address);
                    if (rpt.data_length !== want.data_length)
                        flag_mismatch("data_length", rpt.data_length, want.data_length);
                    if (rpt.signal_strength !== want.signal_strength)
                        flag_mismatch("signal_strength", rpt.signal_strength,
                                      want.signal_strength);
                    if (rpt.data_value !== want.data_value)
                        flag_mismatch("data_value", rpt.data_value, want.data_value);
                    if (rpt.data_offset !== want.data_offset)
                        flag_mismatch("data_offset", rpt.data_offset, want.data_offset);
                    if (rpt.report_time !== want.report_time)
                        flag_mismatch("report_time", rpt.report_time, want.report_time);
                    if (rpt.final_result !== want.final_result)
                        flag_mismatch("final_result", rpt.final_result, want.final_result);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rpt_stall <= 1'b1;
            end
            else if (!pressure_done && results_seen >= PRESSURE_AFTER)
            begin
                pressure_done = 1'b1;
                stall_left    = PRESSURE_CYCLES - 1;
                rpt_stall    <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 15);
                rpt_stall <= 1'b1;
            end
            else
                rpt_stall <= 1'b0;
        end
    end

    // Watchdog: ends the run when neither channel moves for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (pkt_valid && !pkt_stall) || (rpt_valid && !rpt_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] b;
        int         pick;
        int         count;
        int         len;
        int         keep;
        int         made;

        // Directed: stray byte while idle, wrong packet type, wrong event code,
        // report count above the maximum, a start mark cutting a packet short,
        // then a one-report event with all-ones kinds, address and stamp, RSSI 0x80
        // and zero data length, followed by a byte after the last report.
        push_word(8'h5A, 1'b0, '0);
        push_word(8'h05, 1'b1, {63{1'b1}});
        push_word(bleadv_pkg::H4_EVENT_TYPE, 1'b1, '0);
        push_word(8'h3F, 1'b0, rand_stamp());
        push_word(bleadv_pkg::H4_EVENT_TYPE, 1'b1, rand_stamp());
        push_word(bleadv_pkg::LE_META_EVENT, 1'b0, rand_stamp());
        push_word(8'hFF, 1'b0, rand_stamp());
        push_word(bleadv_pkg::ADV_REPORT_SUB, 1'b0, rand_stamp());
        push_word(8'(MAX_REPORTS + 1), 1'b0, rand_stamp());
        push_word(bleadv_pkg::H4_EVENT_TYPE, 1'b1, rand_stamp());
        push_word(bleadv_pkg::LE_META_EVENT, 1'b0, rand_stamp());
        push_word(8'h00, 1'b0, rand_stamp());
        push_word(bleadv_pkg::ADV_REPORT_SUB, 1'b0, rand_stamp());
        push_word(bleadv_pkg::H4_EVENT_TYPE, 1'b1, {63{1'b1}});
        push_word(bleadv_pkg::LE_META_EVENT, 1'b0, '0);
        push_word(8'h00, 1'b0, '0);
        push_word(bleadv_pkg::ADV_REPORT_SUB, 1'b0, '0);
        push_word(8'd1, 1'b0, '0);
        push_word(8'hFF, 1'b0, '0);
        push_word(8'hFF, 1'b0, '0);
        repeat (bleadv_pkg::ADDR_BYTES) push_word(8'hFF, 1'b0, '0);
        push_word(8'h00, 1'b0, '0);
        push_word(8'h80, 1'b0, '0);
        push_word(8'h00, 1'b0, '0);

        // Random: mostly well-formed events with random content, some cut short,
        // the rest header errors and stray bytes.
        made = 0;
        while (pending_words.size() < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                pick = $urandom_range(0, 99);
                if (made == 0 || pick >= 97)
                    count = MAX_REPORTS;
                else if (pick < 60)
                    count = 1;
                else if (pick < 85)
                    count = $urandom_range(2, 3);
                else
                    count = $urandom_range(4, 6);
                made++;
                event_bytes.delete();
                event_bytes.push_back(bleadv_pkg::H4_EVENT_TYPE);
                event_bytes.push_back(bleadv_pkg::LE_META_EVENT);
                event_bytes.push_back(8'($urandom_range(0, 255)));
                event_bytes.push_back(bleadv_pkg::ADV_REPORT_SUB);
                event_bytes.push_back(count[7:0]);
                repeat (count)
                begin
                    // lengths cluster near zero and around capacity, rarely huge
                    pick = $urandom_range(0, 99);
                    if (count > 6)
                        len = $urandom_range(0, 3);
                    else if (pick < 40)
                        len = $urandom_range(0, 4);
                    else if (pick < 75)
                        len = $urandom_range(5, 12);
                    else if (pick < 93)
                        len = $urandom_range(DATA_CAPACITY - 3, DATA_CAPACITY + 3);
                    else if (pick < 98)
                        len = $urandom_range(35, 60);
                    else
                        len = $urandom_range(200, 255);
                    event_bytes.push_back(8'($urandom_range(0, 255)));
                    event_bytes.push_back(8'($urandom_range(0, 255)));
                    repeat (bleadv_pkg::ADDR_BYTES)
                        event_bytes.push_back(8'($urandom_range(0, 255)));
                    event_bytes.push_back(len[7:0]);
                    repeat (len) event_bytes.push_back(8'($urandom_range(0, 255)));
                    event_bytes.push_back(8'($urandom_range(0, 255)));
                end
                keep = event_bytes.size();
                if ($urandom_range(0, 9) == 0)
                    keep = $urandom_range(1, keep - 1);
                foreach (event_bytes[i])
                    if (i < keep)
                        push_word(event_bytes[i], i == 0, rand_stamp());
                if (keep == event_bytes.size() && $urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 3))
                        push_word(8'($urandom_range(0, 255)), 1'b0, rand_stamp());
            end
            else if (pick < 76)
            begin
                // wrong packet type
                b = 8'($urandom_range(0, 255));
                if (b == bleadv_pkg::H4_EVENT_TYPE)
                    b = b ^ 8'h01;
                push_word(b, 1'b1, rand_stamp());
            end
            else if (pick < 82)
            begin
                // wrong event code
                b = 8'($urandom_range(0, 255));
                if (b == bleadv_pkg::LE_META_EVENT)
                    b = b ^ 8'h01;
                push_word(bleadv_pkg::H4_EVENT_TYPE, 1'b1, rand_stamp());
                push_word(b, 1'b0, rand_stamp());
            end
            else if (pick < 88)
            begin
                // wrong subevent
                b = 8'($urandom_range(0, 255));
                if (b == bleadv_pkg::ADV_REPORT_SUB)
                    b = b ^ 8'h01;
                push_word(bleadv_pkg::H4_EVENT_TYPE, 1'b1, rand_stamp());
                push_word(bleadv_pkg::LE_META_EVENT, 1'b0, rand_stamp());
                push_word(8'($urandom_range(0, 255)), 1'b0, rand_stamp());
                push_word(b, 1'b0, rand_stamp());
            end
            else if (pick < 94)
            begin
                // report count zero or above the maximum
                if ($urandom_range(0, 1))
                    b = 8'd0;
                else
                    b = 8'($urandom_range(MAX_REPORTS + 1, 255));
                push_word(bleadv_pkg::H4_EVENT_TYPE, 1'b1, rand_stamp());
                push_word(bleadv_pkg::LE_META_EVENT, 1'b0, rand_stamp());
                push_word(8'($urandom_range(0, 255)), 1'b0, rand_stamp());
                push_word(bleadv_pkg::ADV_REPORT_SUB, 1'b0, rand_stamp());
                push_word(b, 1'b0, rand_stamp());
            end
            else
                repeat ($urandom_range(1, 4))
                    push_word(8'($urandom_range(0, 255)), 1'b0, rand_stamp());
        end
        total_words = pending_words.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (words_taken < total_words)
            @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
